// ----- sv/sbas_pkg.sv -----
// Package with the shared widths, codes and lane control type of the baseline block.
`timescale 1ns / 1ps

package sbas_pkg;

    // Field widths.
    localparam int BAND_W   = 16;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 8;
    localparam int CH_W     = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int NBANDS   = 10;
    localparam int SEQ_W    = $clog2(SUM_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COUNT_W;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT_ENABLE = 1'd1;

    // Default number of optical channels.
    localparam int OPTICAL_CHANNELS_DEF = 3;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_READ    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SAMPLE  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd4;

    // Bit-serial lane operations.
    typedef logic [1:0] sbas_lop_t;
    localparam sbas_lop_t LOP_HOLD = 2'd0;
    localparam sbas_lop_t LOP_ACC  = 2'd1;
    localparam sbas_lop_t LOP_DIV  = 2'd2;
    localparam sbas_lop_t LOP_SUB  = 2'd3;

    // Control bundle from the sequencer to every band lane.
    typedef struct packed {
        logic               load;
        logic               load_base;
        logic               zero_sums;
        logic               restart;
        sbas_lop_t          op;
        logic [COUNT_W-1:0] divisor;
    } sbas_lane_ctl_t;

endpackage

// ----- sv/sbas_in_if.sv -----
// Input channel interface: valid, ready and one item of band readings.
`timescale 1ns / 1ps

interface sbas_in_if;
    logic                         valid;
    logic                         ready;
    logic [sbas_pkg::KIND_W-1:0]  kind;
    logic [sbas_pkg::CH_W-1:0]    optical_channel;
    logic [sbas_pkg::BAND_W-1:0]  band_f1;
    logic [sbas_pkg::BAND_W-1:0]  band_f2;
    logic [sbas_pkg::BAND_W-1:0]  band_f3;
    logic [sbas_pkg::BAND_W-1:0]  band_f4;
    logic [sbas_pkg::BAND_W-1:0]  band_f5;
    logic [sbas_pkg::BAND_W-1:0]  band_f6;
    logic [sbas_pkg::BAND_W-1:0]  band_f7;
    logic [sbas_pkg::BAND_W-1:0]  band_f8;
    logic [sbas_pkg::BAND_W-1:0]  band_clear;
    logic [sbas_pkg::BAND_W-1:0]  band_nir;

    modport source (
        output valid, kind, optical_channel, band_f1, band_f2, band_f3, band_f4,
               band_f5, band_f6, band_f7, band_f8, band_clear, band_nir,
        input  ready
    );

    modport sink (
        input  valid, kind, optical_channel, band_f1, band_f2, band_f3, band_f4,
               band_f5, band_f6, band_f7, band_f8, band_clear, band_nir,
        output ready
    );
endinterface

// ----- sv/sbas_out_if.sv -----
// Output channel interface: valid, ready and one result item.
`timescale 1ns / 1ps

interface sbas_out_if;
    logic                          valid;
    logic                          ready;
    logic [sbas_pkg::STATUS_W-1:0] status;
    logic [sbas_pkg::BAND_W-1:0]   out_f1;
    logic [sbas_pkg::BAND_W-1:0]   out_f2;
    logic [sbas_pkg::BAND_W-1:0]   out_f3;
    logic [sbas_pkg::BAND_W-1:0]   out_f4;
    logic [sbas_pkg::BAND_W-1:0]   out_f5;
    logic [sbas_pkg::BAND_W-1:0]   out_f6;
    logic [sbas_pkg::BAND_W-1:0]   out_f7;
    logic [sbas_pkg::BAND_W-1:0]   out_f8;
    logic [sbas_pkg::BAND_W-1:0]   out_clear;
    logic [sbas_pkg::BAND_W-1:0]   out_nir;

    modport source (
        output valid, status, out_f1, out_f2, out_f3, out_f4, out_f5, out_f6,
               out_f7, out_f8, out_clear, out_nir,
        input  ready
    );

    modport sink (
        input  valid, status, out_f1, out_f2, out_f3, out_f4, out_f5, out_f6,
               out_f7, out_f8, out_clear, out_nir,
        output ready
    );
endinterface

// ----- sv/sbas_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sbas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/sbas_lane.sv -----
// One band lane: bit-serial accumulate, restoring divide and floored subtract.
`timescale 1ns / 1ps

module sbas_lane (
    input  logic                          clk,
    input  sbas_pkg::sbas_lane_ctl_t      ctl,
    input  logic [sbas_pkg::BAND_W-1:0]   band,
    input  logic [sbas_pkg::BAND_W-1:0]   base,
    output logic [sbas_pkg::BAND_W-1:0]   res,
    output logic [sbas_pkg::BAND_W-1:0]   quo
);

    logic [sbas_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [sbas_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic                         cy_reg, cy_next;
    logic [sbas_pkg::BAND_W-1:0]  dat_reg, dat_next;
    logic [sbas_pkg::BAND_W-1:0]  base_reg, base_next;

    // One bit of the current operation per cycle.
    always_comb
    begin
        logic                         a;
        logic                         b;
        logic [sbas_pkg::COUNT_W:0]   r9;
        logic [sbas_pkg::COUNT_W:0]   diff;
        logic                         ge;

        sum_next  = sum_reg;
        rem_next  = rem_reg;
        cy_next   = cy_reg;
        dat_next  = dat_reg;
        base_next = base_reg;
        a         = 1'b0;
        b         = 1'b0;
        r9        = {rem_reg, sum_reg[sbas_pkg::SUM_W-1]};
        diff      = r9 - {1'b0, ctl.divisor};
        ge        = (r9 >= {1'b0, ctl.divisor});

        unique case (ctl.op)
            sbas_pkg::LOP_ACC:
            begin
                // LSB-first add of the band into the sum; a restart adds to zero.
                a        = ctl.restart ? 1'b0 : sum_reg[0];
                b        = dat_reg[0];
                sum_next = {a ^ b ^ cy_reg, sum_reg[sbas_pkg::SUM_W-1:1]};
                cy_next  = (a & b) | (a & cy_reg) | (b & cy_reg);
                dat_next = {1'b0, dat_reg[sbas_pkg::BAND_W-1:1]};
            end
            sbas_pkg::LOP_DIV:
            begin
                // Restoring division, MSB first; quotient bits shift in at the bottom.
                rem_next = ge ? diff[sbas_pkg::COUNT_W-1:0] : r9[sbas_pkg::COUNT_W-1:0];
                sum_next = {sum_reg[sbas_pkg::SUM_W-2:0], ge};
            end
            sbas_pkg::LOP_SUB:
            begin
                // LSB-first subtract of the baseline with a running borrow.
                a         = dat_reg[0];
                b         = base_reg[0];
                dat_next  = {a ^ b ^ cy_reg, dat_reg[sbas_pkg::BAND_W-1:1]};
                cy_next   = (~a & b) | (~(a ^ b) & cy_reg);
                base_next = {1'b0, base_reg[sbas_pkg::BAND_W-1:1]};
            end
            default:
            begin
            end
        endcase

        if (ctl.load)
        begin
            dat_next = band;
            cy_next  = 1'b0;
            rem_next = '0;
        end
        if (ctl.load_base)
        begin
            base_next = base;
        end
        if (ctl.zero_sums)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        cy_reg   <= cy_next;
        dat_reg  <= dat_next;
        base_reg <= base_next;
    end

    // A final borrow means the baseline exceeded the reading: floor at zero.
    assign res = cy_reg ? '0 : dat_reg;
    assign quo = sum_reg[sbas_pkg::BAND_W-1:0];

endmodule

// ----- sv/spectral_baseline_average_subtract.sv -----
// Top level: dark baseline averaging per optical channel and floored subtraction.
//
//  Channel   Role    Handshake            Payload
//  item      sink    valid / ready        kind, optical_channel, ten 16-bit bands
//  result    source  valid / ready        status, ten 16-bit corrected bands
//  cfg       write   cfg_we               cfg_index, cfg_wdata (sample_count, subtract_enable)
//
// Items are processed one at a time by ten bit-serial lanes. A sample is a 24-bit
// serial add; one that completes a run adds a restoring divide and the baseline write.
// A measure with subtraction reads the baseline RAM and does a 16-bit serial subtract.
// The 24-bit sum width sets the longest loops. Reset clears the control state, sets the
// sample count to one and clears every baseline valid bit. The result register lets the
// next transaction be accepted while a finished result is still held.
`timescale 1ns / 1ps

module spectral_baseline_average_subtract #(
    parameter int OPTICAL_CHANNELS = sbas_pkg::OPTICAL_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sbas_in_if.sink                           item,
    sbas_out_if.source                        result,
    input  logic                              cfg_we,
    input  logic [sbas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbas_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int ROW_W = (OPTICAL_CHANNELS > 1) ? $clog2(OPTICAL_CHANNELS) : 1;
    localparam int ROW_BITS = sbas_pkg::NBANDS * sbas_pkg::BAND_W;
    localparam logic [sbas_pkg::CH_W-1:0] CH_MAX = sbas_pkg::CH_W'(OPTICAL_CHANNELS);
    localparam logic [sbas_pkg::SEQ_W-1:0] SEQ_SUM_LAST = sbas_pkg::SEQ_W'(sbas_pkg::SUM_W - 1);
    localparam logic [sbas_pkg::SEQ_W-1:0] SEQ_SUB_LAST =
        sbas_pkg::SEQ_W'(sbas_pkg::BAND_W - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACC    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_WBASE  = 3'd3;
    localparam logic [2:0] ST_LDBASE = 3'd4;
    localparam logic [2:0] ST_SUB    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]                       state_reg, state_next;
    logic [sbas_pkg::SEQ_W-1:0]       seq_reg, seq_next;
    logic [sbas_pkg::COUNT_W-1:0]     taken_reg, taken_next;
    logic [sbas_pkg::CH_W-1:0]        capture_reg, capture_next;
    logic [OPTICAL_CHANNELS-1:0]      valid_reg, valid_next;
    logic [sbas_pkg::COUNT_W-1:0]     sample_count_reg, sample_count_next;
    logic                             sub_en_reg, sub_en_next;
    logic                             restart_reg, restart_next;
    logic [ROW_W-1:0]                 row_reg, row_next;
    logic [sbas_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                             res_zero_reg, res_zero_next;
    logic                             out_valid_reg, out_valid_next;
    logic [sbas_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [sbas_pkg::BAND_W-1:0]      out_band_reg [sbas_pkg::NBANDS];
    logic [sbas_pkg::BAND_W-1:0]      out_band_next [sbas_pkg::NBANDS];

    logic [sbas_pkg::BAND_W-1:0]      in_band [sbas_pkg::NBANDS];
    logic [sbas_pkg::BAND_W-1:0]      lane_res [sbas_pkg::NBANDS];
    logic [sbas_pkg::BAND_W-1:0]      lane_quo [sbas_pkg::NBANDS];
    logic [ROW_BITS-1:0]              quo_row;
    logic [ROW_BITS-1:0]              base_row;
    sbas_pkg::sbas_lane_ctl_t         lane_ctl;

    logic                             accept;
    logic [sbas_pkg::CH_W-1:0]        in_ch;
    logic [ROW_W-1:0]                 in_row;
    logic                             in_ch_ok;
    logic [sbas_pkg::COUNT_W-1:0]     target;
    logic                             rd_en;
    logic                             wr_en;

    // Input fields as a band array.
    assign in_band[0] = item.band_f1;
    assign in_band[1] = item.band_f2;
    assign in_band[2] = item.band_f3;
    assign in_band[3] = item.band_f4;
    assign in_band[4] = item.band_f5;
    assign in_band[5] = item.band_f6;
    assign in_band[6] = item.band_f7;
    assign in_band[7] = item.band_f8;
    assign in_band[8] = item.band_clear;
    assign in_band[9] = item.band_nir;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign in_ch      = item.optical_channel;
    assign in_row     = ROW_W'(in_ch - 2'd1);
    assign in_ch_ok   = (in_ch != '0) && (in_ch <= CH_MAX);
    assign target     = (sample_count_reg == '0) ? 8'd1 : sample_count_reg;

    // Band lanes and the per-channel baseline rows.
    for (genvar i = 0; i < sbas_pkg::NBANDS; i++)
    begin : g_lane
        sbas_lane u_lane (
            .clk  (clk),
            .ctl  (lane_ctl),
            .band (in_band[i]),
            .base (base_row[i*sbas_pkg::BAND_W +: sbas_pkg::BAND_W]),
            .res  (lane_res[i]),
            .quo  (lane_quo[i])
        );
        assign quo_row[i*sbas_pkg::BAND_W +: sbas_pkg::BAND_W] = lane_quo[i];
    end

    sbas_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (OPTICAL_CHANNELS)
    ) u_base_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_reg),
        .wr_data (quo_row),
        .rd_en   (rd_en),
        .rd_addr (in_row),
        .rd_data (base_row)
    );

    // Sequencer, run bookkeeping, configuration and result register.
    always_comb
    begin
        state_next        = state_reg;
        seq_next          = seq_reg;
        taken_next        = taken_reg;
        capture_next      = capture_reg;
        valid_next        = valid_reg;
        sample_count_next = sample_count_reg;
        sub_en_next       = sub_en_reg;
        restart_next      = restart_reg;
        row_next          = row_reg;
        res_status_next   = res_status_reg;
        res_zero_next     = res_zero_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_status_next   = out_status_reg;
        out_band_next     = out_band_reg;
        lane_ctl          = '0;
        lane_ctl.restart  = restart_reg;
        lane_ctl.divisor  = taken_reg;
        rd_en             = 1'b0;
        wr_en             = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == sbas_pkg::REG_SAMPLE_COUNT)
            begin
                sample_count_next = cfg_wdata;
            end
            else if (cfg_index == sbas_pkg::REG_SUBTRACT_ENABLE)
            begin
                sub_en_next = cfg_wdata[0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lane_ctl.load   = 1'b1;
                    res_zero_next   = 1'b1;
                    res_status_next = sbas_pkg::STAT_INVALID;
                    state_next      = ST_DONE;
                    seq_next        = '0;
                    row_next        = in_row;
                    unique case (item.kind)
                        sbas_pkg::KIND_SAMPLE:
                        begin
                            if (in_ch_ok)
                            begin
                                restart_next = (taken_reg == '0) || (in_ch != capture_reg);
                                taken_next   = ((taken_reg == '0) || (in_ch != capture_reg))
                                               ? 8'd1 : 8'(taken_reg + 8'd1);
                                capture_next = in_ch;
                                state_next   = ST_ACC;
                            end
                        end
                        sbas_pkg::KIND_MEASURE:
                        begin
                            if (in_ch == '0)
                            begin
                                res_status_next = sbas_pkg::STAT_READ;
                                res_zero_next   = 1'b0;
                            end
                            else if (in_ch_ok)
                            begin
                                res_status_next = sbas_pkg::STAT_READ;
                                res_zero_next   = 1'b0;
                                if (sub_en_reg && valid_reg[in_row])
                                begin
                                    rd_en      = 1'b1;
                                    state_next = ST_LDBASE;
                                end
                            end
                        end
                        sbas_pkg::KIND_CLEAR:
                        begin
                            if (in_ch == '0)
                            begin
                                valid_next      = '0;
                                res_status_next = sbas_pkg::STAT_CLEARED;
                            end
                            else if (in_ch_ok)
                            begin
                                valid_next[in_row] = 1'b0;
                                res_status_next    = sbas_pkg::STAT_CLEARED;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                lane_ctl.op = sbas_pkg::LOP_ACC;
                seq_next    = sbas_pkg::SEQ_W'(seq_reg + 1'b1);
                if (seq_reg == SEQ_SUM_LAST)
                begin
                    seq_next = '0;
                    if (taken_reg >= target)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        res_status_next = sbas_pkg::STAT_SAMPLE;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                lane_ctl.op = sbas_pkg::LOP_DIV;
                seq_next    = sbas_pkg::SEQ_W'(seq_reg + 1'b1);
                if (seq_reg == SEQ_SUM_LAST)
                begin
                    seq_next   = '0;
                    state_next = ST_WBASE;
                end
            end
            ST_WBASE:
            begin
                // Quotients go to the channel's row; the run closes.
                wr_en               = 1'b1;
                valid_next[row_reg] = 1'b1;
                taken_next          = '0;
                lane_ctl.zero_sums  = 1'b1;
                res_status_next     = sbas_pkg::STAT_STORED;
                state_next          = ST_DONE;
            end
            ST_LDBASE:
            begin
                lane_ctl.load_base = 1'b1;
                seq_next           = '0;
                state_next         = ST_SUB;
            end
            ST_SUB:
            begin
                lane_ctl.op = sbas_pkg::LOP_SUB;
                seq_next    = sbas_pkg::SEQ_W'(seq_reg + 1'b1);
                if (seq_reg == SEQ_SUB_LAST)
                begin
                    seq_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    for (int i = 0; i < sbas_pkg::NBANDS; i++)
                    begin
                        out_band_next[i] = res_zero_reg ? '0 : lane_res[i];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            seq_reg          <= '0;
            taken_reg        <= '0;
            capture_reg      <= '0;
            valid_reg        <= '0;
            sample_count_reg <= 8'd1;
            sub_en_reg       <= 1'b0;
            restart_reg      <= 1'b0;
            row_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seq_reg          <= seq_next;
            taken_reg        <= taken_next;
            capture_reg      <= capture_next;
            valid_reg        <= valid_next;
            sample_count_reg <= sample_count_next;
            sub_en_reg       <= sub_en_next;
            restart_reg      <= restart_next;
            row_reg          <= row_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_zero_reg   <= res_zero_next;
        out_status_reg <= out_status_next;
        out_band_reg   <= out_band_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.status    = out_status_reg;
    assign result.out_f1    = out_band_reg[0];
    assign result.out_f2    = out_band_reg[1];
    assign result.out_f3    = out_band_reg[2];
    assign result.out_f4    = out_band_reg[3];
    assign result.out_f5    = out_band_reg[4];
    assign result.out_f6    = out_band_reg[5];
    assign result.out_f7    = out_band_reg[6];
    assign result.out_f8    = out_band_reg[7];
    assign result.out_clear = out_band_reg[8];
    assign result.out_nir   = out_band_reg[9];

    // The divide never starts with an empty run.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> taken_reg != '0)
        else $error("divide entered with zero samples");

    // Storing a baseline closes the run.
    a_store_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WBASE |=> taken_reg == '0)
        else $error("run not closed after baseline store");

    // The bit counter stays within the sum width.
    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg <= SEQ_SUM_LAST)
        else $error("bit counter out of range");

    // A stored baseline is always readable on the next cycle.
    a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WBASE |=> valid_reg[$past(row_reg)])
        else $error("baseline stored without valid mark");

endmodule

// ----- bench/tb_spectral_baseline_average_subtract.sv -----
// Testbench for the spectral baseline block: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_spectral_baseline_average_subtract;

    localparam int NCH           = sbas_pkg::OPTICAL_CHANNELS_DEF;
    localparam int NBANDS        = sbas_pkg::NBANDS;
    localparam int BAND_W        = sbas_pkg::BAND_W;
    localparam int SUM_W         = sbas_pkg::SUM_W;
    localparam int COUNT_W       = sbas_pkg::COUNT_W;
    localparam int CH_W          = sbas_pkg::CH_W;
    localparam int KIND_W        = sbas_pkg::KIND_W;
    localparam int STATUS_W      = sbas_pkg::STATUS_W;
    localparam int CFG_IDX_W     = sbas_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = sbas_pkg::CFG_DATA_W;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 370;

    // Kind 3 has no operation behind it.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Channel codes; zero addresses no channel or all of them.
    localparam logic [CH_W-1:0] CH_ALL = 2'd0;
    localparam logic [CH_W-1:0] CH_A   = 2'd1;
    localparam logic [CH_W-1:0] CH_B   = 2'd2;
    localparam logic [CH_W-1:0] CH_C   = 2'd3;

    typedef logic [NBANDS-1:0][BAND_W-1:0] band_set_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   ch;
        band_set_t         bands;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        band_set_t           bands;
    } reading_t;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sbas_in_if  item_ch ();
    sbas_out_if result_ch ();

    spectral_baseline_average_subtract dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Predictor state: the running capture, the stored dark baselines and the registers.
    logic [SUM_W-1:0]   sums [NBANDS];
    logic [COUNT_W-1:0] taken;
    logic [CH_W-1:0]    run_ch;
    logic [BAND_W-1:0]  dark [NCH][NBANDS];
    logic               dark_ok [NCH];
    logic [COUNT_W-1:0] count_set;
    logic               sub_on;

    item_t    queued_items [$];
    reading_t expected_readings [$];
    item_t    next_item;
    item_t    seen_item;
    reading_t got;
    reading_t want;

    int  errors      = 0;
    int  cycle_count = 0;
    int  random_made = 0;
    int  send_gap    = 0;
    int  recv_wait   = 0;
    logic in_taken   = 1'b0;
    logic out_taken  = 1'b0;

    string band_names [NBANDS] = '{"out_f1", "out_f2", "out_f3", "out_f4", "out_f5",
                                   "out_f6", "out_f7", "out_f8", "out_clear", "out_nir"};

    // Applies one item to the predictor state and returns the result it should cause.
    function automatic reading_t baseline_step(input item_t it);
        reading_t           r;
        logic [COUNT_W-1:0] target;
        int                 idx;
        r.status = sbas_pkg::STAT_INVALID;
        r.bands  = '0;
        idx      = int'(it.ch) - 1;
        case (it.kind)
            sbas_pkg::KIND_SAMPLE:
            begin
                if (it.ch != CH_ALL && it.ch <= NCH)
                begin
                    // A new channel or an idle capture starts a fresh run.
                    if (taken == '0 || it.ch != run_ch)
                    begin
                        for (int i = 0; i < NBANDS; i++)
                            sums[i] = SUM_W'(it.bands[i]);
                        taken  = COUNT_W'(1);
                        run_ch = it.ch;
                    end
                    else
                    begin
                        for (int i = 0; i < NBANDS; i++)
                            sums[i] = sums[i] + SUM_W'(it.bands[i]);
                        taken = taken + 1'b1;
                    end
                    target = (count_set == '0) ? COUNT_W'(1) : count_set;
                    if (taken >= target && taken != '0)
                    begin
                        for (int i = 0; i < NBANDS; i++)
                        begin
                            dark[idx][i] = BAND_W'(sums[i] / taken);
                            sums[i]      = '0;
                        end
                        dark_ok[idx] = 1'b1;
                        taken        = '0;
                        r.status     = sbas_pkg::STAT_STORED;
                    end
                    else
                    begin
                        r.status = sbas_pkg::STAT_SAMPLE;
                    end
                end
            end
            sbas_pkg::KIND_MEASURE:
            begin
                if (it.ch == CH_ALL)
                begin
                    r.status = sbas_pkg::STAT_READ;
                    r.bands  = it.bands;
                end
                else if (it.ch <= NCH)
                begin
                    r.status = sbas_pkg::STAT_READ;
                    r.bands  = it.bands;
                    // Floored subtraction of the channel's dark baseline.
                    if (sub_on && dark_ok[idx])
                    begin
                        for (int i = 0; i < NBANDS; i++)
                            r.bands[i] = (it.bands[i] > dark[idx][i]) ?
                                         it.bands[i] - dark[idx][i] : '0;
                    end
                end
            end
            sbas_pkg::KIND_CLEAR:
            begin
                if (it.ch == CH_ALL)
                begin
                    for (int c = 0; c < NCH; c++)
                    begin
                        dark_ok[c] = 1'b0;
                        for (int i = 0; i < NBANDS; i++)
                            dark[c][i] = '0;
                    end
                    r.status = sbas_pkg::STAT_CLEARED;
                end
                else if (it.ch <= NCH)
                begin
                    dark_ok[idx] = 1'b0;
                    for (int i = 0; i < NBANDS; i++)
                        dark[idx][i] = '0;
                    r.status = sbas_pkg::STAT_CLEARED;
                end
            end
            default:
            begin
                r.status = sbas_pkg::STAT_INVALID;
            end
        endcase
        return r;
    endfunction

    // Band values with the extremes drawn often.
    function automatic band_set_t random_bands();
        band_set_t b;
        for (int i = 0; i < NBANDS; i++)
        begin
            case ($urandom_range(0, 5))
                0:       b[i] = '0;
                1:       b[i] = '1;
                default: b[i] = BAND_W'($urandom);
            endcase
        end
        return b;
    endfunction

    task automatic push_item(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] c,
                             input band_set_t b);
        item_t it;
        it.kind  = k;
        it.ch    = c;
        it.bands = b;
        queued_items.push_back(it);
    endtask

    // Holds the sender until every transaction has been answered, then lets the block go quiet.
    task automatic settle();
        do
            @(posedge clk);
        while (queued_items.size() != 0 || item_ch.valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        if (idx == sbas_pkg::REG_SAMPLE_COUNT)
            count_set = val;
        else
            sub_on = val[0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly complete capture runs followed by measures, with clears and noise mixed in.
    task automatic random_traffic(input int budget);
        int left;
        int ch;
        int n;
        left = budget;
        while (left > 0)
        begin
            ch = $urandom_range(1, NCH);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    n = (count_set == '0) ? 1 : int'(count_set);
                    // Some runs are cut short so that the next one restarts them.
                    if ($urandom_range(0, 3) == 0)
                        n = $urandom_range(1, n);
                    if (n > left)
                        n = left;
                    repeat (n) push_item(sbas_pkg::KIND_SAMPLE, CH_W'(ch), random_bands());
                    left -= n;
                end
                5, 6, 7:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        push_item(sbas_pkg::KIND_MEASURE, ($urandom_range(0, 3) == 0) ?
                                  CH_W'($urandom_range(0, 3)) : CH_W'(ch), random_bands());
                    left -= n;
                end
                8:
                begin
                    push_item(sbas_pkg::KIND_CLEAR, CH_W'($urandom_range(0, 3)),
                              random_bands());
                    left -= 1;
                end
                default:
                begin
                    push_item(KIND_W'($urandom_range(0, 3)), CH_W'($urandom_range(0, 3)),
                              random_bands());
                    left -= 1;
                end
            endcase
        end
        random_made += budget - left;
    endtask

    // Transactions seen on either side at this edge.
    always @(posedge clk)
    begin
        in_taken  <= rst_n && item_ch.valid && item_ch.ready;
        out_taken <= rst_n && result_ch.valid && result_ch.ready;
    end

    // Sender: presents queued items and idles a drawn number of cycles after each one.
    always @(negedge clk)
    begin
        if (rst_n && !(item_ch.valid && !in_taken))
        begin
            if (send_gap != 0)
            begin
                item_ch.valid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (queued_items.size() != 0)
            begin
                next_item                = queued_items.pop_front();
                item_ch.kind            <= next_item.kind;
                item_ch.optical_channel <= next_item.ch;
                item_ch.band_f1         <= next_item.bands[0];
                item_ch.band_f2         <= next_item.bands[1];
                item_ch.band_f3         <= next_item.bands[2];
                item_ch.band_f4         <= next_item.bands[3];
                item_ch.band_f5         <= next_item.bands[4];
                item_ch.band_f6         <= next_item.bands[5];
                item_ch.band_f7         <= next_item.bands[6];
                item_ch.band_f8         <= next_item.bands[7];
                item_ch.band_clear      <= next_item.bands[8];
                item_ch.band_nir        <= next_item.bands[9];
                item_ch.valid           <= 1'b1;
                send_gap                <= int'($urandom_range(0, 11));
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls each waiting result for a drawn number of cycles.
    always @(negedge clk)
    begin : recv_side
        int w;
        if (rst_n)
        begin
            w = out_taken ? int'($urandom_range(0, 11)) : recv_wait;
            if (w != 0)
            begin
                result_ch.ready <= 1'b0;
                recv_wait       <= result_ch.valid ? w - 1 : w;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                recv_wait       <= 0;
            end
        end
    end

    // Prediction on accepted items, comparison on accepted results, and the run limit.
    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            seen_item.kind      = item_ch.kind;
            seen_item.ch        = item_ch.optical_channel;
            seen_item.bands[0]  = item_ch.band_f1;
            seen_item.bands[1]  = item_ch.band_f2;
            seen_item.bands[2]  = item_ch.band_f3;
            seen_item.bands[3]  = item_ch.band_f4;
            seen_item.bands[4]  = item_ch.band_f5;
            seen_item.bands[5]  = item_ch.band_f6;
            seen_item.bands[6]  = item_ch.band_f7;
            seen_item.bands[7]  = item_ch.band_f8;
            seen_item.bands[8]  = item_ch.band_clear;
            seen_item.bands[9]  = item_ch.band_nir;
            expected_readings.push_back(baseline_step(seen_item));
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.status   = result_ch.status;
            got.bands[0] = result_ch.out_f1;
            got.bands[1] = result_ch.out_f2;
            got.bands[2] = result_ch.out_f3;
            got.bands[3] = result_ch.out_f4;
            got.bands[4] = result_ch.out_f5;
            got.bands[5] = result_ch.out_f6;
            got.bands[6] = result_ch.out_f7;
            got.bands[7] = result_ch.out_f8;
            got.bands[8] = result_ch.out_clear;
            got.bands[9] = result_ch.out_nir;
            if (expected_readings.size() == 0)
            begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                for (int i = 0; i < NBANDS; i++)
                begin
                    if (got.bands[i] !== want.bands[i])
                    begin
                        $error("%s: expected %0d, got %0d", band_names[i], want.bands[i],
                               got.bands[i]);
                        errors++;
                    end
                end
            end
        end
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_spectral_baseline_average_subtract: errors");
            $finish;
        end
    end

    initial
    begin
        // Known values on every input from time zero.
        item_ch.valid           = 1'b0;
        item_ch.kind            = '0;
        item_ch.optical_channel = '0;
        item_ch.band_f1         = '0;
        item_ch.band_f2         = '0;
        item_ch.band_f3         = '0;
        item_ch.band_f4         = '0;
        item_ch.band_f5         = '0;
        item_ch.band_f6         = '0;
        item_ch.band_f7         = '0;
        item_ch.band_f8         = '0;
        item_ch.band_clear      = '0;
        item_ch.band_nir        = '0;
        result_ch.ready         = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_wdata               = '0;

        // Predictor starts from the reset state.
        for (int i = 0; i < NBANDS; i++)
            sums[i] = '0;
        for (int c = 0; c < NCH; c++)
        begin
            dark_ok[c] = 1'b0;
            for (int i = 0; i < NBANDS; i++)
                dark[c][i] = '0;
        end
        taken     = '0;
        run_ch    = CH_ALL;
        count_set = COUNT_W'(1);
        sub_on    = 1'b0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: pass-through, invalid codes, a one-sample baseline and clears.
        push_item(sbas_pkg::KIND_MEASURE, CH_ALL, '1);
        push_item(sbas_pkg::KIND_MEASURE, CH_A, '0);
        push_item(sbas_pkg::KIND_SAMPLE, CH_ALL, random_bands());
        push_item(KIND_UNUSED, CH_A, random_bands());
        push_item(sbas_pkg::KIND_SAMPLE, CH_A, '1);
        push_item(sbas_pkg::KIND_MEASURE, CH_A, random_bands());
        push_item(sbas_pkg::KIND_CLEAR, CH_ALL, random_bands());
        push_item(sbas_pkg::KIND_CLEAR, CH_C, random_bands());

        // Subtraction on with a sample count of zero, which acts as one.
        settle();
        write_reg(sbas_pkg::REG_SUBTRACT_ENABLE, CFG_DATA_W'(1));
        write_reg(sbas_pkg::REG_SAMPLE_COUNT, CFG_DATA_W'(0));
        push_item(sbas_pkg::KIND_SAMPLE, CH_B, random_bands());
        push_item(sbas_pkg::KIND_MEASURE, CH_B, '1);
        push_item(sbas_pkg::KIND_MEASURE, CH_B, '0);
        push_item(sbas_pkg::KIND_MEASURE, CH_C, random_bands());
        push_item(sbas_pkg::KIND_MEASURE, CH_ALL, random_bands());

        // Two-sample runs: a channel change restarts the run, and a clear leaves it going.
        settle();
        write_reg(sbas_pkg::REG_SAMPLE_COUNT, CFG_DATA_W'(2));
        push_item(sbas_pkg::KIND_SAMPLE, CH_A, random_bands());
        push_item(sbas_pkg::KIND_SAMPLE, CH_C, random_bands());
        push_item(sbas_pkg::KIND_SAMPLE, CH_C, random_bands());
        push_item(sbas_pkg::KIND_SAMPLE, CH_B, random_bands());
        push_item(sbas_pkg::KIND_CLEAR, CH_B, random_bands());
        push_item(sbas_pkg::KIND_SAMPLE, CH_B, random_bands());
        push_item(sbas_pkg::KIND_MEASURE, CH_B, random_bands());

        // The count is lowered below the samples already summed.
        settle();
        write_reg(sbas_pkg::REG_SAMPLE_COUNT, CFG_DATA_W'(3));
        push_item(sbas_pkg::KIND_SAMPLE, CH_A, random_bands());
        push_item(sbas_pkg::KIND_SAMPLE, CH_A, random_bands());
        settle();
        write_reg(sbas_pkg::REG_SAMPLE_COUNT, CFG_DATA_W'(1));
        push_item(sbas_pkg::KIND_SAMPLE, CH_A, random_bands());
        push_item(sbas_pkg::KIND_MEASURE, CH_A, random_bands());
        push_item(sbas_pkg::KIND_MEASURE, CH_C, random_bands());

        // Longest run at the largest count.
        settle();
        write_reg(sbas_pkg::REG_SAMPLE_COUNT, CFG_DATA_W'(255));
        write_reg(sbas_pkg::REG_SUBTRACT_ENABLE, CFG_DATA_W'(1));
        repeat (255) push_item(sbas_pkg::KIND_SAMPLE, CH_C, random_bands());
        random_made = 255;
        random_traffic(20);

        // Random phases with fresh settings each time.
        while (random_made < RANDOM_ITEMS)
        begin
            settle();
            write_reg(sbas_pkg::REG_SAMPLE_COUNT, CFG_DATA_W'($urandom_range(0, 6)));
            write_reg(sbas_pkg::REG_SUBTRACT_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
            random_traffic(40);
        end

        settle();
        if (errors == 0)
            $display("tb_spectral_baseline_average_subtract: clean");
        else
            $display("tb_spectral_baseline_average_subtract: errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sbas_pkg.sv
sv/sbas_in_if.sv
sv/sbas_out_if.sv
sv/sbas_ram.sv
sv/sbas_lane.sv
sv/spectral_baseline_average_subtract.sv
bench/tb_spectral_baseline_average_subtract.sv
